[rtl/ev_pilot_charge_controller_top_macros.svh]
// ---------------------------------------------------------------------------
// EV pilot charge controller assertion macros
// Shared property wrappers for the concurrent checks of the top level.
// ---------------------------------------------------------------------------
`ifndef EV_PILOT_CHARGE_CONTROLLER_TOP_MACROS_SVH
`define EV_PILOT_CHARGE_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define EVPCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EVPCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/evpcc_pkg.sv]
// ---------------------------------------------------------------------------
// EV pilot charge controller package
// Types, codes and constants shared by the controller modules.
// ---------------------------------------------------------------------------
`default_nettype none

package evpcc_pkg;

  localparam int unsigned ADC_BITS           = 10;
  localparam int unsigned FAN_DELAY_TICKS    = 2000;
  localparam int unsigned TEST_TIMEOUT_TICKS = 1000;
  localparam int unsigned FAULT_PULSE_PERIOD = 5000;
  localparam int unsigned MAX_TRIES          = 3;
  localparam int unsigned RETRY_WAIT_TICKS   = 1000;

  localparam logic [9:0] ADC_MASK =
    (ADC_BITS >= 10) ? 10'h3ff : 10'(((1 << ADC_BITS) - 1));

  localparam logic [7:0]  SETTLE_TICKS = 8'd100;
  localparam logic [12:0] PULSE_TICKS  = 13'd100;
  localparam logic [10:0] FWD_EXPECT   = 11'd640;
  localparam logic [10:0] REV_EXPECT   = 11'd416;
  localparam logic [10:0] FWD_MARGIN   = 11'd100;
  localparam logic [9:0]  DROP_MARGIN  = 10'd20;
  localparam logic [2:0]  DROP_LIMIT   = 3'd5;
  localparam logic [5:0]  BLINK_TICKS  = 6'd50;
  localparam logic [7:0]  PWM_POS      = 8'd255;
  localparam logic [7:0]  PWM_NEG      = 8'd0;
  localparam logic [7:0]  PWM_ZERO     = 8'd85;
  // floor(x / 100) = (x * 10486) >> 20 for x below 4096
  localparam logic [13:0] DIV100_MUL   = 14'd10486;

  localparam logic [2:0] CFG_LEVEL_A  = 3'd0;
  localparam logic [2:0] CFG_LEVEL_B  = 3'd1;
  localparam logic [2:0] CFG_LEVEL_C  = 3'd2;
  localparam logic [2:0] CFG_LEVEL_D  = 3'd3;
  localparam logic [2:0] CFG_LEVEL_E  = 3'd4;
  localparam logic [2:0] CFG_DEBOUNCE = 3'd5;
  localparam logic [2:0] CFG_AMPS     = 3'd6;
  localparam logic [2:0] CFG_DIODE    = 3'd7;

  typedef enum logic [2:0] {
    ST_A = 3'd0, ST_B = 3'd1, ST_C = 3'd2, ST_D = 3'd3,
    ST_E = 3'd4, ST_F = 3'd5, ST_X = 3'd6, ST_T = 3'd7
  } pstate_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0, PH_INIT = 3'd1, PH_NEG = 3'd2,
    PH_POS  = 3'd3, PH_DONE = 3'd4, PH_WAIT = 3'd5
  } phase_e;

  typedef struct packed {
    logic [9:0]  level_a;
    logic [9:0]  level_b;
    logic [9:0]  level_c;
    logic [9:0]  level_d;
    logic [9:0]  level_e;
    logic [15:0] debounce;
    logic [5:0]  amps;
    logic [7:0]  tol;
  } cfg_t;

  typedef struct packed {
    pstate_e     main;
    phase_e      phase;
    logic [15:0] since;
    logic [10:0] tel;
    logic [7:0]  sel;
    logic [11:0] fel;
    logic        fan_active;
    logic [12:0] fpe;
    logic        pulse_busy;
    logic [9:0]  fwd;
    logic [9:0]  rev;
    logic        passed;
    logic [1:0]  tries;
    logic [2:0]  drop;
    logic [5:0]  blink;
    logic [7:0]  pwm;
    logic        relay;
    logic        fan;
    logic        chg;
    logic        top;
    logic        bot;
    logic        mdn;
    logic        mup;
  } st_t;

  function automatic logic [7:0] duty_for(input logic [5:0] amps);
    logic [7:0] v;
    case (amps)
      6'd6:    v = 8'd25;
      6'd7:    v = 8'd29;
      6'd8:    v = 8'd34;
      6'd9:    v = 8'd38;
      6'd10:   v = 8'd42;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/evpcc_classify.sv]
// ---------------------------------------------------------------------------
// EV pilot level classifier
// Sorts one pilot reading into states A to F against the threshold set.
// ---------------------------------------------------------------------------
`default_nettype none

module evpcc_classify (
  input  wire logic [9:0]       pilot_i,
  input  wire evpcc_pkg::cfg_t  cfg_i,
  output evpcc_pkg::pstate_e    det_o
);

  always_comb begin
    if (pilot_i > cfg_i.level_a) begin
      det_o = evpcc_pkg::ST_A;
    end else if (pilot_i > cfg_i.level_b) begin
      det_o = evpcc_pkg::ST_B;
    end else if (pilot_i > cfg_i.level_c) begin
      det_o = evpcc_pkg::ST_C;
    end else if (pilot_i > cfg_i.level_d) begin
      det_o = evpcc_pkg::ST_D;
    end else if (pilot_i > cfg_i.level_e) begin
      det_o = evpcc_pkg::ST_E;
    end else begin
      det_o = evpcc_pkg::ST_F;
    end
  end

endmodule

`default_nettype wire

[rtl/evpcc_step.sv]
// ---------------------------------------------------------------------------
// EV pilot tick update
// Next controller state for one millisecond tick and its pilot reading.
// ---------------------------------------------------------------------------
`default_nettype none

module evpcc_step (
  input  wire logic [9:0]       pilot_i,
  input  wire evpcc_pkg::cfg_t  cfg_i,
  input  wire evpcc_pkg::st_t   st_i,
  output evpcc_pkg::st_t        st_o
);

  evpcc_pkg::pstate_e det;

  evpcc_classify u_classify (
    .pilot_i (pilot_i),
    .cfg_i   (cfg_i),
    .det_o   (det)
  );

  function automatic evpcc_pkg::st_t f_drive_off(input evpcc_pkg::st_t s);
    evpcc_pkg::st_t r;
    r = s;
    r.chg = 1'b0;
    r.relay = 1'b0;
    r.fan = 1'b0;
    r.fan_active = 1'b0;
    return r;
  endfunction

  function automatic evpcc_pkg::st_t f_clear_test(input evpcc_pkg::st_t s);
    evpcc_pkg::st_t r;
    r = s;
    r.phase = evpcc_pkg::PH_IDLE;
    r.passed = 1'b0;
    r.tries = 2'd0;
    r.fwd = 10'd0;
    r.rev = 10'd0;
    r.tel = 11'd0;
    r.sel = 8'd0;
    return r;
  endfunction

  function automatic evpcc_pkg::st_t f_emergency(input evpcc_pkg::st_t s);
    evpcc_pkg::st_t r;
    r = f_clear_test(f_drive_off(s));
    r.main = evpcc_pkg::ST_F;
    r.pwm = evpcc_pkg::PWM_NEG;
    r.top = 1'b0;
    r.bot = 1'b0;
    r.mdn = 1'b0;
    r.mup = 1'b0;
    return r;
  endfunction

  function automatic evpcc_pkg::st_t f_current(input evpcc_pkg::st_t s,
                                               input logic [5:0] amps);
    evpcc_pkg::st_t r;
    r = s;
    if (amps >= 6'd6 && amps <= 6'd10) begin
      r.pwm = evpcc_pkg::duty_for(amps);
    end
    return r;
  endfunction

  function automatic evpcc_pkg::st_t f_enter(input evpcc_pkg::st_t s,
                                             input evpcc_pkg::pstate_e to,
                                             input logic [5:0] amps);
    evpcc_pkg::st_t r;
    r = s;
    r.main = to;
    case (to)
      evpcc_pkg::ST_A: begin
        r = f_clear_test(f_drive_off(r));
        r.pwm = evpcc_pkg::PWM_POS;
      end
      evpcc_pkg::ST_B: begin
        r = f_clear_test(f_drive_off(r));
      end
      evpcc_pkg::ST_C: begin
        if (!r.passed) begin
          r = f_emergency(r);
        end else begin
          r = f_drive_off(r);
          r.chg = 1'b1;
          r.relay = 1'b1;
          r = f_current(r, amps);
        end
      end
      evpcc_pkg::ST_D: begin
        if (!r.passed) begin
          r = f_emergency(r);
        end else begin
          r = f_drive_off(r);
          r.fan = 1'b1;
          r.fan_active = 1'b1;
          r.fel = 12'd0;
          r = f_current(r, amps);
        end
      end
      evpcc_pkg::ST_E: begin
        r = f_drive_off(r);
        r.pwm = evpcc_pkg::PWM_ZERO;
      end
      default: r = f_emergency(r);
    endcase
    return r;
  endfunction

  function automatic evpcc_pkg::st_t f_begin(input evpcc_pkg::st_t s);
    evpcc_pkg::st_t r;
    r = s;
    r.phase = evpcc_pkg::PH_INIT;
    r.tel = 11'd0;
    r.sel = 8'd0;
    if (r.tries != 2'd3) begin
      r.tries = r.tries + 2'd1;
    end
    r.main = evpcc_pkg::ST_T;
    r.fwd = 10'd0;
    r.rev = 10'd0;
    r.passed = 1'b0;
    return r;
  endfunction

  function automatic evpcc_pkg::st_t f_finish(input evpcc_pkg::st_t s,
                                              input logic ok,
                                              input evpcc_pkg::pstate_e to,
                                              input logic [5:0] amps);
    evpcc_pkg::st_t r;
    r = s;
    r.phase = evpcc_pkg::PH_IDLE;
    if (ok) begin
      r.tries = 2'd0;
      r = f_enter(r, to, amps);
    end else if (r.tries >= 2'(evpcc_pkg::MAX_TRIES)) begin
      r = f_emergency(r);
    end else if (evpcc_pkg::RETRY_WAIT_TICKS == 0) begin
      r = f_begin(r);
    end else begin
      r.phase = evpcc_pkg::PH_WAIT;
      r.tel = 11'd0;
    end
    return r;
  endfunction

  function automatic logic f_legal(input evpcc_pkg::pstate_e from,
                                   input evpcc_pkg::pstate_e to);
    logic l;
    case (from)
      evpcc_pkg::ST_A: l = to == evpcc_pkg::ST_B || to == evpcc_pkg::ST_E ||
                           to == evpcc_pkg::ST_F;
      evpcc_pkg::ST_B: l = to != evpcc_pkg::ST_B && to != evpcc_pkg::ST_X;
      evpcc_pkg::ST_C,
      evpcc_pkg::ST_D: l = to == evpcc_pkg::ST_B || to == evpcc_pkg::ST_A ||
                           to == evpcc_pkg::ST_E || to == evpcc_pkg::ST_F;
      evpcc_pkg::ST_E: l = to == evpcc_pkg::ST_A || to == evpcc_pkg::ST_F;
      evpcc_pkg::ST_T: l = to != evpcc_pkg::ST_E && to != evpcc_pkg::ST_T;
      evpcc_pkg::ST_X: l = to == evpcc_pkg::ST_F || to == evpcc_pkg::ST_A;
      default:         l = to == evpcc_pkg::ST_A;
    endcase
    return l;
  endfunction

  evpcc_pkg::st_t s;
  logic           done;
  logic           chk;
  logic           ok;
  logic [10:0]    fw;
  logic [10:0]    rv;
  logic [10:0]    tol;
  logic [25:0]    fel_prod;

  always_comb begin
    s = st_i;
    done = 1'b0;
    chk = 1'b0;
    ok = 1'b0;
    fw = 11'(st_i.fwd);
    rv = 11'(st_i.rev);
    tol = 11'(cfg_i.tol);
    fel_prod = 26'd0;

    s.since = s.since + 16'(s.since != '1);
    s.tel   = s.tel + 11'(s.tel != '1);
    s.sel   = s.sel + 8'(s.sel != '1);
    s.fel   = s.fel + 12'(s.fel != '1);
    s.fpe   = s.fpe + 13'(s.fpe != '1);

    if (s.main == evpcc_pkg::ST_F) begin
      if (!s.pulse_busy && s.fpe > 13'(evpcc_pkg::FAULT_PULSE_PERIOD)) begin
        s.pwm = evpcc_pkg::PWM_POS;
        s.pulse_busy = 1'b1;
        s.fpe = 13'd0;
      end
      if (s.pulse_busy && s.fpe > evpcc_pkg::PULSE_TICKS) begin
        s.pulse_busy = 1'b0;
        if (pilot_i > cfg_i.level_a) begin
          s = f_enter(s, evpcc_pkg::ST_A, cfg_i.amps);
          s.pwm = evpcc_pkg::PWM_POS;
          done = 1'b1;
        end else begin
          s.pwm = evpcc_pkg::PWM_NEG;
        end
      end
    end

    if (!done && s.phase != evpcc_pkg::PH_IDLE) begin
      done = 1'b1;
      case (s.phase)
        evpcc_pkg::PH_INIT: begin
          s.pwm = evpcc_pkg::PWM_NEG;
          s.phase = evpcc_pkg::PH_NEG;
          s.sel = 8'd0;
          chk = 1'b1;
        end
        evpcc_pkg::PH_NEG: begin
          if (s.sel >= evpcc_pkg::SETTLE_TICKS) begin
            s.rev = pilot_i;
            s.pwm = evpcc_pkg::PWM_POS;
            s.phase = evpcc_pkg::PH_POS;
            s.sel = 8'd0;
          end
          chk = 1'b1;
        end
        evpcc_pkg::PH_POS: begin
          if (s.sel >= evpcc_pkg::SETTLE_TICKS) begin
            s.fwd = pilot_i;
            s.phase = evpcc_pkg::PH_DONE;
          end
          chk = 1'b1;
        end
        evpcc_pkg::PH_DONE: begin
          ok = (fw + tol >= evpcc_pkg::FWD_EXPECT) &&
               (fw <= evpcc_pkg::FWD_EXPECT + tol) &&
               (rv <= evpcc_pkg::REV_EXPECT + tol) &&
               (fw > rv + evpcc_pkg::FWD_MARGIN);
          s.passed = ok;
          s = f_finish(s, ok, det, cfg_i.amps);
        end
        evpcc_pkg::PH_WAIT: begin
          if (s.tel >= 11'(evpcc_pkg::RETRY_WAIT_TICKS)) begin
            s = f_begin(s);
          end
        end
        default: ;
      endcase
      if (chk && s.tel > 11'(evpcc_pkg::TEST_TIMEOUT_TICKS)) begin
        s = f_finish(s, 1'b0, det, cfg_i.amps);
      end
    end

    if (!done) begin
      if (s.chg) begin
        s.blink = s.blink + 6'd1;
        if (s.blink >= evpcc_pkg::BLINK_TICKS) begin
          s.blink = 6'd0;
          s.mup = s.mdn;
          s.mdn = !s.mdn;
        end
      end
      if (det != s.main && s.since > cfg_i.debounce) begin
        if (f_legal(s.main, det)) begin
          if ((det == evpcc_pkg::ST_C || det == evpcc_pkg::ST_D) && !s.passed) begin
            s = f_begin(s);
            done = 1'b1;
          end else begin
            s = f_enter(s, det, cfg_i.amps);
            s.since = 16'd0;
          end
        end else begin
          s = f_emergency(s);
        end
      end
    end

    if (!done) begin
      if (s.main == evpcc_pkg::ST_D && s.fan_active &&
          s.fel >= 12'(evpcc_pkg::FAN_DELAY_TICKS) && !s.chg && s.fan) begin
        s.chg = 1'b1;
        s.relay = 1'b1;
      end
      if (s.main == evpcc_pkg::ST_C) begin
        if (cfg_i.level_c >= evpcc_pkg::DROP_MARGIN &&
            pilot_i < cfg_i.level_c - evpcc_pkg::DROP_MARGIN) begin
          if (s.drop != 3'd7) begin
            s.drop = s.drop + 3'd1;
          end
          if (s.drop >= evpcc_pkg::DROP_LIMIT) begin
            s = f_emergency(s);
          end
        end else begin
          s.drop = 3'd0;
        end
      end
      fel_prod = 26'(s.fel) * 26'(evpcc_pkg::DIV100_MUL);
      case (s.main)
        evpcc_pkg::ST_A: begin
          s.top = 1'b1; s.bot = 1'b0; s.mdn = 1'b0; s.mup = 1'b0;
        end
        evpcc_pkg::ST_B: begin
          s.top = 1'b1; s.bot = 1'b1; s.mdn = 1'b0; s.mup = 1'b0;
        end
        evpcc_pkg::ST_C: begin
          s.top = 1'b1; s.bot = 1'b1;
        end
        evpcc_pkg::ST_D: begin
          s.top = 1'b1; s.bot = 1'b1;
          if (s.fan && !s.chg) begin
            s.mdn = fel_prod[20];
            s.mup = !fel_prod[20];
          end
        end
        evpcc_pkg::ST_E,
        evpcc_pkg::ST_F: begin
          s.top = 1'b0; s.bot = 1'b0; s.mdn = 1'b0; s.mup = 1'b0;
        end
        default: ;
      endcase
    end

    st_o = s;
  end

endmodule

`default_nettype wire

[rtl/ev_pilot_charge_controller_top.sv]
// ---------------------------------------------------------------------------
// EV pilot charge controller
// Control pilot state machine with diode test, fan delay and fault recovery.
// ---------------------------------------------------------------------------
// One request is one 1 ms tick with its peak pilot reading. A request is held
// in an input register, its whole tick update runs in a single pass of logic
// into the state and result registers once the result register is free, and
// the next request is taken in the very same cycle: one request per cycle
// while the result is not stalled. Only a stalled result holds off the
// input. Each request yields exactly one result carrying the present drive
// values. Configuration writes are taken at any time; write only while idle.
`default_nettype none

`include "ev_pilot_charge_controller_top_macros.svh"

module ev_pilot_charge_controller_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output      logic       cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [9:0] pilot_peak_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic [2:0] pilot_state_o,
  output      logic [7:0] pilot_pwm_o,
  output      logic       contactor_on_o,
  output      logic       fan_on_o,
  output      logic       charging_flag_o,
  output      logic       led_top_o,
  output      logic       led_bottom_o,
  output      logic       led_mid_down_o,
  output      logic       led_mid_up_o
);

  localparam evpcc_pkg::st_t RESET_STATE = '{
    main:    evpcc_pkg::ST_A,
    phase:   evpcc_pkg::PH_IDLE,
    pwm:     evpcc_pkg::PWM_POS,
    top:     1'b1,
    default: '0
  };

  evpcc_pkg::cfg_t cfg_q;
  evpcc_pkg::st_t  st_q;
  evpcc_pkg::st_t  st_d;
  logic            in_vld_q;
  logic [9:0]      pilot_q;
  logic            advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_vld_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o  = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_a  <= 10'd730;
      cfg_q.level_b  <= 10'd685;
      cfg_q.level_c  <= 10'd640;
      cfg_q.level_d  <= 10'd595;
      cfg_q.level_e  <= 10'd550;
      cfg_q.debounce <= 16'd500;
      cfg_q.amps     <= 6'd10;
      cfg_q.tol      <= 8'd40;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        evpcc_pkg::CFG_LEVEL_A:  cfg_q.level_a  <= cfg_data_i[9:0];
        evpcc_pkg::CFG_LEVEL_B:  cfg_q.level_b  <= cfg_data_i[9:0];
        evpcc_pkg::CFG_LEVEL_C:  cfg_q.level_c  <= cfg_data_i[9:0];
        evpcc_pkg::CFG_LEVEL_D:  cfg_q.level_d  <= cfg_data_i[9:0];
        evpcc_pkg::CFG_LEVEL_E:  cfg_q.level_e  <= cfg_data_i[9:0];
        evpcc_pkg::CFG_DEBOUNCE: cfg_q.debounce <= cfg_data_i;
        evpcc_pkg::CFG_AMPS:     cfg_q.amps     <= cfg_data_i[5:0];
        evpcc_pkg::CFG_DIODE:    cfg_q.tol      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      pilot_q <= pilot_peak_i & evpcc_pkg::ADC_MASK;
    end
  end

  evpcc_step u_step (
    .pilot_i (pilot_q),
    .cfg_i   (cfg_q),
    .st_i    (st_q),
    .st_o    (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q            <= RESET_STATE;
      out_valid_o     <= 1'b0;
      pilot_state_o   <= evpcc_pkg::ST_A;
      pilot_pwm_o     <= evpcc_pkg::PWM_POS;
      contactor_on_o  <= 1'b0;
      fan_on_o        <= 1'b0;
      charging_flag_o <= 1'b0;
      led_top_o       <= 1'b1;
      led_bottom_o    <= 1'b0;
      led_mid_down_o  <= 1'b0;
      led_mid_up_o    <= 1'b0;
    end else if (advance) begin
      st_q            <= st_d;
      out_valid_o     <= 1'b1;
      pilot_state_o   <= st_d.main;
      pilot_pwm_o     <= st_d.pwm;
      contactor_on_o  <= st_d.relay;
      fan_on_o        <= st_d.fan;
      charging_flag_o <= st_d.chg;
      led_top_o       <= st_d.top;
      led_bottom_o    <= st_d.bot;
      led_mid_down_o  <= st_d.mdn;
      led_mid_up_o    <= st_d.mup;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  `EVPCC_ASSERT_IMP(a_relay_state, contactor_on_o,
    pilot_state_o == evpcc_pkg::ST_C || pilot_state_o == evpcc_pkg::ST_D,
    "contactor closed outside states C and D")
  `EVPCC_ASSERT_IMP(a_chg_relay, charging_flag_o, contactor_on_o,
    "charging without contactor")
  `EVPCC_ASSERT_NXT(a_advance_out, advance, out_valid_o,
    "tick update produced no result")

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// EV pilot charge controller testbench
// Drives one peak pilot reading per request and compares every result with a
// cycle-free model of the pilot state machine, diode test and drive logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [2:0] state;
    logic [7:0] pwm;
    logic       relay;
    logic       fan;
    logic       chg;
    logic       top;
    logic       bot;
    logic       mdn;
    logic       mup;
  } drive_t;

  class pilot_scoreboard;
    int      lvl [5];
    int      debounce, amps, tol;
    evpcc_pkg::pstate_e main;
    evpcc_pkg::phase_e  phase;
    int      since, tel, sel, fel, fpe;
    bit      fan_active, pbusy, passed;
    int      fwd, rev, tries, drop, blink;
    int      pwm;
    bit      relay, fan, chg, top, bot, mdn, mup;
    drive_t  expected_q [$];

    function new();
      lvl = '{730, 685, 640, 595, 550};
      debounce = 500; amps = 10; tol = 40;
      main = evpcc_pkg::ST_A; since = 0; fel = 0; fpe = 0; pbusy = 0; drop = 0; blink = 0;
      clear_test(); drive_off();
      pwm = 255; top = 1; bot = 0; mdn = 0; mup = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        evpcc_pkg::CFG_LEVEL_A, evpcc_pkg::CFG_LEVEL_B, evpcc_pkg::CFG_LEVEL_C,
        evpcc_pkg::CFG_LEVEL_D, evpcc_pkg::CFG_LEVEL_E:
          lvl[idx] = d[9:0];
        evpcc_pkg::CFG_DEBOUNCE: debounce = d;
        evpcc_pkg::CFG_AMPS:     amps = d[5:0];
        default:                 tol = d[7:0];
      endcase
    endfunction

    function evpcc_pkg::pstate_e classify(int p);
      if (p > lvl[0]) return evpcc_pkg::ST_A;
      if (p > lvl[1]) return evpcc_pkg::ST_B;
      if (p > lvl[2]) return evpcc_pkg::ST_C;
      if (p > lvl[3]) return evpcc_pkg::ST_D;
      if (p > lvl[4]) return evpcc_pkg::ST_E;
      return evpcc_pkg::ST_F;
    endfunction

    function bit legal(evpcc_pkg::pstate_e f, evpcc_pkg::pstate_e t);
      case (f)
        evpcc_pkg::ST_A:
          return t == evpcc_pkg::ST_B || t == evpcc_pkg::ST_E || t == evpcc_pkg::ST_F;
        evpcc_pkg::ST_B: return t != evpcc_pkg::ST_B && t != evpcc_pkg::ST_X;
        evpcc_pkg::ST_C, evpcc_pkg::ST_D:
          return t == evpcc_pkg::ST_B || t == evpcc_pkg::ST_A ||
                 t == evpcc_pkg::ST_E || t == evpcc_pkg::ST_F;
        evpcc_pkg::ST_E: return t == evpcc_pkg::ST_A || t == evpcc_pkg::ST_F;
        evpcc_pkg::ST_T: return t != evpcc_pkg::ST_E && t != evpcc_pkg::ST_T;
        evpcc_pkg::ST_X: return t == evpcc_pkg::ST_F || t == evpcc_pkg::ST_A;
        default: return t == evpcc_pkg::ST_A;
      endcase
    endfunction

    function void clear_test();
      phase = evpcc_pkg::PH_IDLE;
      passed = 0; tries = 0; fwd = 0; rev = 0; tel = 0; sel = 0;
    endfunction

    function void drive_off();
      chg = 0; relay = 0; fan = 0; fan_active = 0;
    endfunction

    function void emergency();
      drive_off(); main = evpcc_pkg::ST_F; clear_test();
      pwm = 0; top = 0; bot = 0; mdn = 0; mup = 0;
    endfunction

    function void set_current();
      if (amps >= 6 && amps <= 10) pwm = amps * 255 / 60;
    endfunction

    function void enter(evpcc_pkg::pstate_e s);
      main = s;
      case (s)
        evpcc_pkg::ST_A: begin drive_off(); pwm = 255; clear_test(); end
        evpcc_pkg::ST_B: begin drive_off(); clear_test(); end
        evpcc_pkg::ST_C: begin
          if (!passed) begin emergency(); return; end
          drive_off(); chg = 1; relay = 1; set_current();
        end
        evpcc_pkg::ST_D: begin
          if (!passed) begin emergency(); return; end
          drive_off(); fan = 1; fan_active = 1; fel = 0; set_current();
        end
        evpcc_pkg::ST_E: begin drive_off(); pwm = 85; end
        default: emergency();
      endcase
    endfunction

    function void begin_test();
      phase = evpcc_pkg::PH_INIT; tel = 0; sel = 0;
      if (tries < 3) tries++;
      main = evpcc_pkg::ST_T; fwd = 0; rev = 0; passed = 0;
    endfunction

    function void finish_test(bit ok, int p);
      phase = evpcc_pkg::PH_IDLE;
      if (ok) begin
        tries = 0; enter(classify(p));
      end else if (tries >= evpcc_pkg::MAX_TRIES) begin
        main = evpcc_pkg::ST_X; emergency();
      end else if (evpcc_pkg::RETRY_WAIT_TICKS == 0) begin
        begin_test();
      end else begin
        phase = evpcc_pkg::PH_WAIT; tel = 0;
      end
    endfunction

    function void run_test(int p);
      bit ok;
      case (phase)
        evpcc_pkg::PH_INIT: begin pwm = 0; phase = evpcc_pkg::PH_NEG; sel = 0; end
        evpcc_pkg::PH_NEG:
          if (sel >= 100) begin rev = p; pwm = 255; phase = evpcc_pkg::PH_POS; sel = 0; end
        evpcc_pkg::PH_POS:
          if (sel >= 100) begin fwd = p; phase = evpcc_pkg::PH_DONE; end
        evpcc_pkg::PH_DONE: begin
          ok = fwd >= 640 - tol && fwd <= 640 + tol && rev <= 416 + tol && fwd > rev + 100;
          passed = ok;
          finish_test(ok, p);
          return;
        end
        evpcc_pkg::PH_WAIT: begin
          if (tel >= evpcc_pkg::RETRY_WAIT_TICKS) begin_test();
          return;
        end
        default: return;
      endcase
      if (tel > evpcc_pkg::TEST_TIMEOUT_TICKS) finish_test(0, p);
    endfunction

    function void set_lamps();
      bit odd;
      case (main)
        evpcc_pkg::ST_A: begin top = 1; bot = 0; mdn = 0; mup = 0; end
        evpcc_pkg::ST_B: begin top = 1; bot = 1; mdn = 0; mup = 0; end
        evpcc_pkg::ST_C: begin top = 1; bot = 1; end
        evpcc_pkg::ST_D: begin
          top = 1; bot = 1;
          if (fan && !chg) begin
            odd = ((fel / 100) % 2) != 0;
            mdn = odd; mup = !odd;
          end
        end
        evpcc_pkg::ST_E, evpcc_pkg::ST_F: begin top = 0; bot = 0; mdn = 0; mup = 0; end
        default: ;
      endcase
    endfunction

    function void advance(int p);
      evpcc_pkg::pstate_e det;
      if (since < 65535) since++;
      if (tel < 2047) tel++;
      if (sel < 255) sel++;
      if (fel < 4095) fel++;
      if (fpe < 8191) fpe++;
      if (main == evpcc_pkg::ST_F) begin
        if (!pbusy && fpe > evpcc_pkg::FAULT_PULSE_PERIOD) begin
          pwm = 255; pbusy = 1; fpe = 0;
        end
        if (pbusy && fpe > 100) begin
          pbusy = 0;
          if (p > lvl[0]) begin enter(evpcc_pkg::ST_A); pwm = 255; return; end
          pwm = 0;
        end
      end
      if (phase != evpcc_pkg::PH_IDLE) begin run_test(p); return; end
      if (chg) begin
        blink++;
        if (blink >= 50) begin
          blink = 0;
          if (mdn) begin mdn = 0; mup = 1; end
          else begin mdn = 1; mup = 0; end
        end
      end
      det = classify(p);
      if (det != main && since > debounce) begin
        if (legal(main, det)) begin
          if ((det == evpcc_pkg::ST_C || det == evpcc_pkg::ST_D) && !passed) begin
            begin_test();
            return;
          end
          enter(det);
          since = 0;
        end else begin
          emergency();
        end
      end
      if (main == evpcc_pkg::ST_D && fan_active && fel >= evpcc_pkg::FAN_DELAY_TICKS &&
          !chg && fan) begin
        chg = 1; relay = 1;
      end
      if (main == evpcc_pkg::ST_C) begin
        if (p < lvl[2] - 20) begin
          if (drop < 7) drop++;
          if (drop >= 5) emergency();
        end else begin
          drop = 0;
        end
      end
      set_lamps();
    endfunction

    function void note_request(logic [9:0] p);
      drive_t d;
      advance(int'(p));
      d = '{main, pwm[7:0], relay, fan, chg, top, bot, mdn, mup};
      expected_q.push_back(d);
    endfunction

    function bit check_result(drive_t got, output string msg);
      drive_t e;
      msg = "";
      if (expected_q.size() == 0) begin
        msg = "result with nothing expected";
        return 0;
      end
      e = expected_q.pop_front();
      if (got.state !== e.state) msg = {msg, $sformatf(" state %0d/%0d", got.state, e.state)};
      if (got.pwm !== e.pwm) msg = {msg, $sformatf(" pwm %0d/%0d", got.pwm, e.pwm)};
      if (got.relay !== e.relay) msg = {msg, $sformatf(" relay %b/%b", got.relay, e.relay)};
      if (got.fan !== e.fan) msg = {msg, $sformatf(" fan %b/%b", got.fan, e.fan)};
      if (got.chg !== e.chg) msg = {msg, $sformatf(" chg %b/%b", got.chg, e.chg)};
      if (got.top !== e.top) msg = {msg, $sformatf(" top %b/%b", got.top, e.top)};
      if (got.bot !== e.bot) msg = {msg, $sformatf(" bot %b/%b", got.bot, e.bot)};
      if (got.mdn !== e.mdn) msg = {msg, $sformatf(" mdn %b/%b", got.mdn, e.mdn)};
      if (got.mup !== e.mup) msg = {msg, $sformatf(" mup %b/%b", got.mup, e.mup)};
      return msg == "";
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 600000;

  logic        clk_i = 0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [9:0]  pilot_peak_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  pilot_state_o;
  logic [7:0]  pilot_pwm_o;
  logic        contactor_on_o, fan_on_o, charging_flag_o;
  logic        led_top_o, led_bottom_o, led_mid_down_o, led_mid_up_o;

  pilot_scoreboard sb = new();
  int mismatches = 0;
  int cycles = 0;
  int hold_off = 0;
  evpcc_pkg::pstate_e target = evpcc_pkg::ST_A;

  ev_pilot_charge_controller_top u_dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  task automatic report(string msg);
    mismatches++;
    $display("mismatch at %0t:%s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    drive_t got;
    string  msg;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{pilot_state_o, pilot_pwm_o, contactor_on_o, fan_on_o, charging_flag_o,
              led_top_o, led_bottom_o, led_mid_down_o, led_mid_up_o};
      if (!sb.check_result(got, msg)) report(msg);
    end
  end

  initial begin
    int mode, mode_left;
    mode = 0; mode_left = 0;
    out_stall_i = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        hold_off--;
        out_stall_i <= 1;
      end else begin
        if (mode_left <= 0) begin
          mode = $urandom_range(2);
          mode_left = $urandom_range(300, 20);
        end
        mode_left--;
        out_stall_i <= (mode == 0) ? 1'b0 :
                       (mode == 1) ? ($urandom_range(3) == 0) : ($urandom_range(3) != 0);
      end
    end
  end

  int burst_left = 0;

  task automatic send_tick(logic [9:0] p);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(40, 1);
      if ($urandom_range(3) != 0) begin
        @(negedge clk_i);
        in_valid_i <= 0;
        repeat ($urandom_range(9)) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i   <= 1;
    pilot_peak_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(p);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= 16'(val) | 16'($urandom() << ((idx == evpcc_pkg::CFG_DEBOUNCE) ? 16 :
                   (idx == evpcc_pkg::CFG_AMPS) ? 6 : (idx == evpcc_pkg::CFG_DIODE) ? 8 : 10));
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(cfg_index_i, cfg_data_i);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic write_all(int a, int b, int c, int d, int e, int deb, int am, int tl);
    write_reg(evpcc_pkg::CFG_LEVEL_A, a);
    write_reg(evpcc_pkg::CFG_LEVEL_B, b);
    write_reg(evpcc_pkg::CFG_LEVEL_C, c);
    write_reg(evpcc_pkg::CFG_LEVEL_D, d);
    write_reg(evpcc_pkg::CFG_LEVEL_E, e);
    write_reg(evpcc_pkg::CFG_DEBOUNCE, deb);
    write_reg(evpcc_pkg::CFG_AMPS, am);
    write_reg(evpcc_pkg::CFG_DIODE, tl);
  endtask

  function automatic logic [9:0] level_for(evpcc_pkg::pstate_e s);
    int hi, lo;
    if ($urandom_range(99) < 4) return $urandom_range(1023);
    case (sb.phase)
      evpcc_pkg::PH_NEG: if ($urandom_range(99) < 85) return $urandom_range(430, 330);
      evpcc_pkg::PH_POS: if ($urandom_range(99) < 85) return $urandom_range(665, 615);
      default: ;
    endcase
    hi = (s == evpcc_pkg::ST_A) ? 1023 : sb.lvl[int'(s) - 1];
    lo = (s == evpcc_pkg::ST_F) ? 0 : sb.lvl[int'(s)] + 1;
    if (hi < lo) return $urandom_range(1023);
    return $urandom_range(hi, lo);
  endfunction

  task automatic hold_level(evpcc_pkg::pstate_e s, int n);
    repeat (n) send_tick(level_for(s));
  endtask

  function automatic evpcc_pkg::pstate_e next_target();
    if ($urandom_range(9) == 0) return evpcc_pkg::pstate_e'($urandom_range(5));
    case (sb.main)
      evpcc_pkg::ST_A:
        return ($urandom_range(3) != 0) ? evpcc_pkg::ST_B :
               ($urandom_range(1) ? evpcc_pkg::ST_E : evpcc_pkg::ST_F);
      evpcc_pkg::ST_B:
        return ($urandom_range(3) == 0) ? evpcc_pkg::ST_A :
               ($urandom_range(1) ? evpcc_pkg::ST_C : evpcc_pkg::ST_D);
      evpcc_pkg::ST_C, evpcc_pkg::ST_D:
        return ($urandom_range(2) == 0) ? evpcc_pkg::ST_A : evpcc_pkg::ST_B;
      evpcc_pkg::ST_T: return target;
      default: return evpcc_pkg::ST_A;
    endcase
  endfunction

  task automatic random_run(int n);
    int hold, sent;
    sent = 0;
    while (sent < n) begin
      target = next_target();
      hold = (sb.debounce > 60) ? $urandom_range(40, 5) : sb.debounce + $urandom_range(30, 1);
      if (sb.phase != evpcc_pkg::PH_IDLE) hold = $urandom_range(60, 20);
      hold_level(target, hold);
      sent += hold;
    end
    drain();
  endtask

  task automatic random_setting();
    int a, b, c, d, e;
    a = $urandom_range(1000, 560);
    b = a - $urandom_range(60, 5);
    c = b - $urandom_range(60, 5);
    d = c - $urandom_range(60, 5);
    e = d - $urandom_range(60, 5);
    write_all(a, b, c, d, e, $urandom_range(30),
              ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(10, 6),
              $urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(80, 20));
  endtask

  initial begin
    logic [9:0] directed [$];
    rst_ni = 0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 0; pilot_peak_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    directed = '{10'd0, 10'd1023, 10'h155, 10'h2aa, 10'd731, 10'd730, 10'd686, 10'd685,
                 10'd641, 10'd640, 10'd596, 10'd595, 10'd551, 10'd550};
    for (int i = 0; i < 10; i++) directed.push_back(10'(1 << i));
    foreach (directed[i]) send_tick(directed[i]);
    drain();

    write_all(730, 685, 640, 595, 550, 3, 6, 40);
    random_run(180);
    write_all(730, 685, 640, 595, 550, 0, 10, 255);
    hold_off = 400;
    random_run(180);
    write_all(1023, 1023, 1023, 1023, 1023, 0, 0, 0);
    random_run(40);
    write_all(0, 0, 0, 0, 0, 65535, 63, 0);
    random_run(40);
    write_all(900, 600, 15, 8, 4, 2, 7, 60);
    random_run(140);

    write_all(730, 685, 640, 595, 550, 2, 8, 60);
    hold_level(evpcc_pkg::ST_A, 20);
    hold_level(evpcc_pkg::ST_B, 20);
    for (int t = 0; t < 20 && sb.main != evpcc_pkg::ST_D; t++) begin
      hold_level(evpcc_pkg::ST_D, 20);
    end
    hold_level(evpcc_pkg::ST_D, 200);
    hold_level(evpcc_pkg::ST_B, 20);
    hold_level(evpcc_pkg::ST_F, 60);
    hold_level(evpcc_pkg::ST_A, 40);
    drain();

    for (int k = 0; k < 4; k++) begin
      random_setting();
      random_run(100);
    end
    write_all(730, 685, 640, 595, 550, 1, 9, 40);
    random_run(120);

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
